// ===== hw/rtl/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and character mapping for integer_to_ascii_digits
// no dependencies; used by itoa_bcd_step, itoa_out_reg and integer_to_ascii_digits
package itoa_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned MagW     = 32;
  localparam int unsigned DecDigits = 10;
  localparam int unsigned HexDigits = 16;
  localparam int unsigned BcdW     = DecDigits * 4;
  localparam int unsigned CharW    = 7;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CntW     = 5;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_LHEX = 2'd2,
    OP_UHEX = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChMinus = 7'h2d;
  localparam logic [CharW-1:0] ChUpA   = 7'h41;
  localparam logic [CharW-1:0] ChLowA  = 7'h61;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             is_last;
    logic [LenW-1:0]  total_length;
  } char_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CharW-1:0] r;
    if (d < 4'd10) begin
      r = ChZero + CharW'(d);
    end else if (upper) begin
      r = ChUpA + CharW'(d - 4'd10);
    end else begin
      r = ChLowA + CharW'(d - 4'd10);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_digits.sv =====
// integer_to_ascii_digits: top level, sequencer around a shared bcd step unit
// depends on itoa_pkg, itoa_bcd_step and itoa_out_reg
//
// Input channel: in_valid_i / in_stall_o carry op_i and value_i. One item is
// a number and a mode (signed or unsigned 32-bit decimal, lower or upper
// 64-bit hex). Output channel: out_valid_o / out_stall_i carry one character
// per item, most significant first, no leading zeros, with a leading '-' for
// negative signed values. The last character has is_last_o set and carries
// total_length_o; all others carry zero length.
// Sequence: decimal items run the shift-and-add-3 conversion in the shared bcd
// step unit, then a leading-zero scan, then one character per cycle while the
// output register is free (up to 11 characters with a sign). Hex items skip
// the conversion and go straight to the scan. The next item can be taken in
// the cycle after the last character is loaded.
// in_stall_o is high from acceptance until the last character is loaded into
// the output register, so the next item may be taken while it still waits.
// A stalled receiver holds the output register and pauses the emission.
// Reset clears the sequencer and the output valid; the block is then idle.
module integer_to_ascii_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [itoa_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itoa_pkg::CharW-1:0]    character_o,
  output logic                          is_last_o,
  output logic [itoa_pkg::LenW-1:0]     total_length_o
);

  itoa_pkg::state_e state_q, state_d;
  logic [itoa_pkg::HexDigits-1:0][3:0] digits_q, digits_d;
  logic [itoa_pkg::MagW-1:0]  bin_q, bin_d;
  logic [itoa_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [itoa_pkg::LenW-1:0]  ndig_q, ndig_d;
  logic [itoa_pkg::LenW-1:0]  total_q, total_d;
  logic                       neg_q, neg_d;
  logic                       upper_q, upper_d;

  logic [itoa_pkg::BcdW-1:0]  bcd_next;
  logic [itoa_pkg::MagW-1:0]  bin_next;
  logic [itoa_pkg::MagW-1:0]  low_word;
  logic [3:0]                 idx;
  logic [3:0]                 cur_digit;
  logic                       accept;
  logic                       load;
  logic                       free;
  itoa_pkg::char_t            char_d;
  itoa_pkg::char_t            char_q;

  itoa_bcd_step u_bcd_step (
    .bcd_i (digits_q[itoa_pkg::DecDigits-1:0]),
    .bin_i (bin_q),
    .bcd_o (bcd_next),
    .bin_o (bin_next)
  );

  itoa_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .data_i      (char_d),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (char_q)
  );

  assign in_stall_o = (state_q != itoa_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign low_word   = value_i[itoa_pkg::MagW-1:0];
  assign idx        = 4'(ndig_q - itoa_pkg::LenW'(1));
  assign cur_digit  = digits_q[idx];

  always_comb begin
    state_d  = state_q;
    digits_d = digits_q;
    bin_d    = bin_q;
    cnt_d    = cnt_q;
    ndig_d   = ndig_q;
    total_d  = total_q;
    neg_d    = neg_q;
    upper_d  = upper_q;
    load     = 1'b0;
    char_d   = '0;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (accept) begin
          upper_d = (op_i == itoa_pkg::OP_UHEX);
          if (op_i == itoa_pkg::OP_SDEC || op_i == itoa_pkg::OP_UDEC) begin
            neg_d    = (op_i == itoa_pkg::OP_SDEC) && low_word[itoa_pkg::MagW-1];
            bin_d    = neg_d ? (~low_word + itoa_pkg::MagW'(1)) : low_word;
            digits_d = '0;
            cnt_d    = itoa_pkg::CntW'(itoa_pkg::MagW - 1);
            ndig_d   = itoa_pkg::LenW'(itoa_pkg::DecDigits);
            state_d  = itoa_pkg::ST_CONV;
          end else begin
            neg_d    = 1'b0;
            digits_d = value_i;
            ndig_d   = itoa_pkg::LenW'(itoa_pkg::HexDigits);
            state_d  = itoa_pkg::ST_SKIP;
          end
        end
      end
      itoa_pkg::ST_CONV: begin
        digits_d[itoa_pkg::DecDigits-1:0] = bcd_next;
        bin_d = bin_next;
        cnt_d = cnt_q - itoa_pkg::CntW'(1);
        if (cnt_q == '0) begin
          state_d = itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SKIP: begin
        if (ndig_q > itoa_pkg::LenW'(1) && cur_digit == 4'd0) begin
          ndig_d = ndig_q - itoa_pkg::LenW'(1);
        end else begin
          total_d = ndig_q + itoa_pkg::LenW'(neg_q);
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (free) begin
          load = 1'b1;
          if (neg_q) begin
            char_d.character = itoa_pkg::ChMinus;
            neg_d = 1'b0;
          end else begin
            char_d.character = itoa_pkg::digit_char(cur_digit, upper_q);
            ndig_d = ndig_q - itoa_pkg::LenW'(1);
            if (ndig_q == itoa_pkg::LenW'(1)) begin
              char_d.is_last      = 1'b1;
              char_d.total_length = total_q;
              state_d             = itoa_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
      neg_q   <= 1'b0;
      ndig_q  <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      ndig_q  <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    bin_q    <= bin_d;
    cnt_q    <= cnt_d;
    total_q  <= total_d;
    upper_q  <= upper_d;
  end

  assign character_o    = char_q.character;
  assign is_last_o      = char_q.is_last;
  assign total_length_o = char_q.total_length;

  // last character always reports a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> total_length_o != '0)
    else $error("last item without length");

  // only the last character carries a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> total_length_o == '0)
    else $error("length on non-last item");

  // an accepted number keeps the input stalled in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a sign is only ever pending while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_q |-> in_stall_o)
    else $error("sign pending while idle");

endmodule

// ===== hw/rtl/itoa_bcd_step.sv =====
// itoa_bcd_step: one shift-and-add-3 step of binary to bcd conversion
// depends on itoa_pkg
module itoa_bcd_step (
  input  logic [itoa_pkg::BcdW-1:0] bcd_i,
  input  logic [itoa_pkg::MagW-1:0] bin_i,
  output logic [itoa_pkg::BcdW-1:0] bcd_o,
  output logic [itoa_pkg::MagW-1:0] bin_o
);

  logic [itoa_pkg::DecDigits-1:0][3:0] adj;

  always_comb begin
    for (int i = 0; i < itoa_pkg::DecDigits; i++) begin
      adj[i] = (bcd_i[i*4 +: 4] >= 4'd5) ? bcd_i[i*4 +: 4] + 4'd3 : bcd_i[i*4 +: 4];
    end
  end

  assign bcd_o = {adj[itoa_pkg::DecDigits-1][2:0], adj[itoa_pkg::DecDigits-2:0],
                  bin_i[itoa_pkg::MagW-1]};
  assign bin_o = {bin_i[itoa_pkg::MagW-2:0], 1'b0};

endmodule

// ===== hw/rtl/itoa_out_reg.sv =====
// itoa_out_reg: output register for one character item with valid/stall handshake
// depends on itoa_pkg
module itoa_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  itoa_pkg::char_t      data_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output itoa_pkg::char_t      data_o
);

  logic            valid_q, valid_d;
  itoa_pkg::char_t data_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

// ===== test/tb_integer_to_ascii_digits.sv =====
// tb_integer_to_ascii_digits: self-checking testbench for integer_to_ascii_digits
// directed table then random numbers, characters checked against typed text or a string predictor
// depends on itoa_pkg and the integer_to_ascii_digits rtl
module tb_integer_to_ascii_digits;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom   = 150;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 64;
  localparam int StuckLimit  = 5000;

  typedef struct {
    itoa_pkg::op_e op;
    logic [63:0]   value;
    string         text;
  } num_case_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    op_i = itoa_pkg::OP_SDEC;
  logic [itoa_pkg::ValueW-1:0]   value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [itoa_pkg::CharW-1:0]    character_o;
  logic                          is_last_o;
  logic [itoa_pkg::LenW-1:0]     total_length_o;

  itoa_pkg::char_t pending_chars[$];
  int              errors = 0;
  bit              quiet = 1'b0;
  bit              hold_out = 1'b0;

  // typed text only where it is obvious, empty text means use the predictor
  num_case_t dir_cases [22] = '{
    '{itoa_pkg::OP_SDEC, 64'd0, "0"},
    '{itoa_pkg::OP_UDEC, 64'd0, "0"},
    '{itoa_pkg::OP_LHEX, 64'd0, "0"},
    '{itoa_pkg::OP_UHEX, 64'd0, "0"},
    '{itoa_pkg::OP_SDEC, 64'h0000_0000_8000_0000, "-2147483648"},
    '{itoa_pkg::OP_SDEC, 64'h0000_0000_7fff_ffff, "2147483647"},
    '{itoa_pkg::OP_SDEC, 64'h0000_0000_ffff_ffff, "-1"},
    '{itoa_pkg::OP_UDEC, 64'h0000_0000_ffff_ffff, "4294967295"},
    '{itoa_pkg::OP_UDEC, 64'hffff_ffff_0000_0000, "0"},
    '{itoa_pkg::OP_SDEC, 64'hffff_ffff_0000_0005, "5"},
    '{itoa_pkg::OP_SDEC, 64'h0000_0000_ffff_fff6, "-10"},
    '{itoa_pkg::OP_UDEC, 64'd1000000000, "1000000000"},
    '{itoa_pkg::OP_LHEX, 64'hffff_ffff_ffff_ffff, "ffffffffffffffff"},
    '{itoa_pkg::OP_UHEX, 64'hffff_ffff_ffff_ffff, "FFFFFFFFFFFFFFFF"},
    '{itoa_pkg::OP_LHEX, 64'h0123_4567_89ab_cdef, "123456789abcdef"},
    '{itoa_pkg::OP_UHEX, 64'hfedc_ba98_7654_3210, "FEDCBA9876543210"},
    '{itoa_pkg::OP_UHEX, 64'h8000_0000_0000_0000, "8000000000000000"},
    '{itoa_pkg::OP_LHEX, 64'd10, "a"},
    '{itoa_pkg::OP_UHEX, 64'd15, "F"},
    '{itoa_pkg::OP_UDEC, 64'h5a5a_a5a5_0000_0009, ""},
    '{itoa_pkg::OP_SDEC, 64'ha5a5_5a5a_8000_0001, ""},
    '{itoa_pkg::OP_LHEX, 64'h5555_aaaa_3c3c_c3c3, ""}
  };

  integer_to_ascii_digits u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .is_last_o      (is_last_o),
    .total_length_o (total_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic string spell_number(input itoa_pkg::op_e op, input logic [63:0] v);
    logic [31:0] mag;
    bit          neg;
    string       s;
    if (op == itoa_pkg::OP_SDEC || op == itoa_pkg::OP_UDEC) begin
      mag = v[31:0];
      neg = (op == itoa_pkg::OP_SDEC) && mag[31];
      if (neg) mag = -mag;
      s = $sformatf("%0d", mag);
      if (neg) s = {"-", s};
    end else begin
      s = $sformatf("%0h", v);
      if (op == itoa_pkg::OP_UHEX) s = s.toupper();
    end
    return s;
  endfunction

  function automatic void expect_text(input string s);
    itoa_pkg::char_t c;
    byte             ch;
    for (int i = 0; i < s.len(); i++) begin
      ch             = s[i];
      c.character    = ch[itoa_pkg::CharW-1:0];
      c.is_last      = (i == s.len() - 1);
      c.total_length = c.is_last ? itoa_pkg::LenW'(s.len()) : '0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    logic [63:0] p;
    int          w;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = 64'($urandom_range(0, 20));
      2: begin
        w = $urandom_range(1, 64);
        v = v & ((64'd1 << w) - 64'd1);
      end
      3: begin
        p = 64'd1;
        repeat ($urandom_range(0, 9)) p = p * 64'd10;
        v = {v[63:32], 32'(p + 64'($urandom_range(0, 2)) - 64'd1)};
      end
      4: v = {v[63:32], ($urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                              : 32'hffff_ffff - $urandom_range(0, 3))};
      default: v = 64'd1 << $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic send_number(input itoa_pkg::op_e op, input logic [63:0] v,
                             input string text);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    expect_text(text != "" ? text : spell_number(op, v));
  endtask

  // receiver stall bursts, calm stretches and one long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_out = 1'b0;
      end else if (!quiet) begin
        if ($urandom_range(0, 3) == 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 16)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end else begin
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    itoa_pkg::char_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: character expected none got %h", $time, character_o);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.character) begin
          $display("%0t: character expected %h got %h", $time, want.character, character_o);
          errors++;
        end
        if (is_last_o !== want.is_last) begin
          $display("%0t: is_last expected %b got %b", $time, want.is_last, is_last_o);
          errors++;
        end
        if (total_length_o !== want.total_length) begin
          $display("%0t: total_length expected %0d got %0d", $time, want.total_length,
                   total_length_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_cases[i]) send_number(dir_cases[i].op, dir_cases[i].value, dir_cases[i].text);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 40) hold_out = 1'b1;
      if (n == 100) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_chars.size() != 0);
      end
      quiet = (n >= NumRandom - 30);
      send_number(itoa_pkg::op_e'($urandom_range(0, 3)), rand_value(), "");
    end
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
